>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Both macros sample on clk and are disabled while arst_n is low.
// With SYNTH defined they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_PROP(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

`define ASSERT_NEVER(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(name, prop)
`define ASSERT_NEVER(name, expr)

`endif

`endif

>>> hdl/rbos_pkg.sv
// ----------------------------------------------------------------------------
// rbos_pkg
// Types, sizes and the sort key for the render batch order sorter.
// ----------------------------------------------------------------------------
package rbos_pkg;

	localparam int MAX_RECORDS      = 64;
	localparam int BATCH_INDEX_BITS = 16;
	localparam int DEPTH_BITS       = 32;
	localparam int ADDR_W           = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int CNT_W            = $clog2(MAX_RECORDS + 1);
	localparam int GROUP_W          = 4;
	localparam int KEY_W            = GROUP_W + DEPTH_BITS + ADDR_W;

	typedef logic [KEY_W-1:0] key_t;

	// one stored record; depth_key is the depth with its sign bit flipped
	typedef struct packed {
		logic                        hud;
		logic                        flood;
		logic                        flat;
		logic                        translucent;
		logic [DEPTH_BITS-1:0]       depth_key;
		logic [BATCH_INDEX_BITS-1:0] index;
	} rec_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_FLUSH,
		ST_OUT
	} state_t;

	// Unique ascending key: draw group, then inverted depth for non-hud
	// translucent records, then arrival slot (keeps ties stable).
	// With no special record the arrival slot alone decides.
	function automatic key_t rec_key(rec_t r, logic special, logic [ADDR_W-1:0] addr);
		logic [GROUP_W-1:0]    grp;
		logic [DEPTH_BITS-1:0] dk;
		begin
			grp = r.hud ? 4'b1000 : {1'b0, r.flood, r.flat, r.translucent};
			dk  = (!r.hud && r.translucent) ? ~r.depth_key : '0;
			if (special) begin
				rec_key = {grp, dk, addr};
			end else begin
				rec_key = {{(GROUP_W + DEPTH_BITS){1'b0}}, addr};
			end
		end
	endfunction

endpackage

>>> hdl/render_batch_order_sorter.sv
// ----------------------------------------------------------------------------
// render_batch_order_sorter
// Painter's-style draw order for one set of draw-batch records.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one record per item, one cycle
//   each while loading. Included records go into a 64-entry store; extra
//   included records are dropped and mark the set as overflowed.
//   The record with last = 1 closes the set. in_stall then stays high
//   until every result of the set has been taken.
//   Result channel (res_valid / res_stall): one item per stored record, in
//   draw order, last_res on the final one. An empty set gives a single
//   item with none_included = 1 and batch_index_res = 0.
//   Timing: each result comes from one full scan of the store through a
//   single key comparator on the store's one read port, then a flush
//   state and the output state; the scans start after the last record.
//   A stalled result holds in its output registers; the scan for the next
//   result starts once it is taken.
//   Reset (arst_n low) empties the set and returns to loading; store
//   contents are not cleared, only entries below the count are read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module render_batch_order_sorter (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   included,
	input  logic                                   hud,
	input  logic                                   flood,
	input  logic                                   flat,
	input  logic                                   translucent,
	input  logic signed [31:0]                     sort_depth,
	input  logic [rbos_pkg::BATCH_INDEX_BITS-1:0]  batch_index,
	input  logic                                   last,
	output logic                                   res_valid,
	input  logic                                   res_stall,
	output logic [rbos_pkg::BATCH_INDEX_BITS-1:0]  batch_index_res,
	output logic                                   last_res,
	output logic                                   none_included,
	output logic                                   overflow
);

	localparam int CW = rbos_pkg::CNT_W;
	localparam int AW = rbos_pkg::ADDR_W;

	rbos_pkg::state_t state_q, state_nxt;

	// record store
	rbos_pkg::rec_t store_mem [rbos_pkg::MAX_RECORDS];
	rbos_pkg::rec_t rd_data_s1;
	rbos_pkg::rec_t wr_rec;

	// set bookkeeping
	logic [CW-1:0] count_q;
	logic          any_special_q;
	logic          overflowed_q;
	logic          none_q;

	// scan sequencer
	logic [AW-1:0] scan_addr_q;
	logic [AW-1:0] addr_s1;
	logic          rd_vld_s1;
	logic [CW-1:0] out_cnt_q;
	logic          have_prev_q;
	logic          best_vld_q;
	rbos_pkg::key_t prev_key_q;
	rbos_pkg::key_t best_key_q;
	logic [rbos_pkg::BATCH_INDEX_BITS-1:0] best_idx_q;

	logic          in_acc, res_acc;
	logic          store_ok;
	logic [CW-1:0] count_nxt;
	logic          special_nxt;
	logic          ovf_nxt;
	logic          scan_end;
	logic          out_end;
	rbos_pkg::key_t cand_key;
	logic          cand_take;

	assign in_acc = in_valid && !in_stall;
	assign res_acc = res_valid && !res_stall;

	// load-side next values
	assign store_ok    = included && (count_q < CW'(rbos_pkg::MAX_RECORDS));
	assign count_nxt   = count_q + CW'(store_ok);
	assign special_nxt = any_special_q | (store_ok & (hud | flood | translucent));
	assign ovf_nxt     = overflowed_q | (included & !store_ok);

	assign wr_rec = '{hud: hud, flood: flood, flat: flat, translucent: translucent,
		depth_key: $unsigned(sort_depth) ^ 32'h8000_0000, index: batch_index};

	assign scan_end = ({1'b0, scan_addr_q} == (count_q - CW'(1)));
	assign out_end  = none_q || ((out_cnt_q + CW'(1)) == count_q);

	// shared comparator: smallest key strictly above the previous pick
	assign cand_key  = rbos_pkg::rec_key(rd_data_s1, any_special_q, addr_s1);
	assign cand_take = rd_vld_s1 && (!have_prev_q || (cand_key > prev_key_q)) &&
		(!best_vld_q || (cand_key < best_key_q));

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rbos_pkg::ST_LOAD: begin
				if (in_acc && last) begin
					state_nxt = (count_nxt == '0) ? rbos_pkg::ST_OUT : rbos_pkg::ST_SCAN;
				end
			end
			rbos_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_nxt = rbos_pkg::ST_FLUSH;
				end
			end
			rbos_pkg::ST_FLUSH: begin
				state_nxt = rbos_pkg::ST_OUT;
			end
			rbos_pkg::ST_OUT: begin
				if (res_acc) begin
					state_nxt = out_end ? rbos_pkg::ST_LOAD : rbos_pkg::ST_SCAN;
				end
			end
			default: begin
				state_nxt = rbos_pkg::ST_LOAD;
			end
		endcase
	end

	// handshake outputs
	always_comb begin
		in_stall  = 1'b1;
		res_valid = 1'b0;
		case (state_q)
			rbos_pkg::ST_LOAD: begin
				in_stall = 1'b0;
			end
			rbos_pkg::ST_OUT: begin
				res_valid = 1'b1;
			end
			default: begin
				in_stall  = 1'b1;
				res_valid = 1'b0;
			end
		endcase
	end

	assign batch_index_res = none_q ? '0 : best_idx_q;
	assign last_res        = out_end;
	assign none_included   = none_q;
	assign overflow        = overflowed_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= rbos_pkg::ST_LOAD;
			count_q       <= '0;
			any_special_q <= 1'b0;
			overflowed_q  <= 1'b0;
			none_q        <= 1'b0;
			scan_addr_q   <= '0;
			rd_vld_s1     <= 1'b0;
			out_cnt_q     <= '0;
			have_prev_q   <= 1'b0;
			best_vld_q    <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			rd_vld_s1 <= (state_q == rbos_pkg::ST_SCAN);
			if (cand_take) begin
				best_vld_q <= 1'b1;
			end
			case (state_q)
				rbos_pkg::ST_LOAD: begin
					if (in_acc) begin
						count_q       <= count_nxt;
						any_special_q <= special_nxt;
						overflowed_q  <= ovf_nxt;
						if (last) begin
							none_q      <= (count_nxt == '0);
							scan_addr_q <= '0;
							out_cnt_q   <= '0;
							have_prev_q <= 1'b0;
							best_vld_q  <= 1'b0;
						end
					end
				end
				rbos_pkg::ST_SCAN: begin
					scan_addr_q <= scan_addr_q + AW'(1);
				end
				rbos_pkg::ST_OUT: begin
					if (res_acc) begin
						if (out_end) begin
							count_q       <= '0;
							any_special_q <= 1'b0;
							overflowed_q  <= 1'b0;
							none_q        <= 1'b0;
						end else begin
							out_cnt_q   <= out_cnt_q + CW'(1);
							scan_addr_q <= '0;
							have_prev_q <= 1'b1;
							best_vld_q  <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		addr_s1 <= scan_addr_q;
		if (cand_take) begin
			best_key_q <= cand_key;
			best_idx_q <= rd_data_s1.index;
		end
		if (res_acc) begin
			prev_key_q <= best_key_q;
		end
	end

	// store: one write port while loading, one registered read for the scan
	always_ff @(posedge clk) begin
		if (in_acc && store_ok) begin
			store_mem[count_q[AW-1:0]] <= wr_rec;
		end
		rd_data_s1 <= store_mem[scan_addr_q];
	end

	`ASSERT_PROP(a_res_blocks_load, res_valid |-> in_stall)
	`ASSERT_NEVER(a_count_range, count_q > CW'(rbos_pkg::MAX_RECORDS))
	`ASSERT_PROP(a_last_clears, (res_acc && last_res) |=> (count_q == '0 && !overflowed_q))
	`ASSERT_PROP(a_none_empty, (res_valid && none_included) |-> (count_q == '0))
	`ASSERT_PROP(a_pick_found, (res_valid && !none_included) |-> best_vld_q)

endmodule

>>> verif/render_batch_order_sorter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// render_batch_order_sorter_tb
// Self-checking bench for the draw-batch order sorter. Record sets are pushed
// through the input channel, and a scoreboard works out the draw order of
// every closed set. Each result item is compared with the oldest predicted
// one. The run covers directed corner sets, then random sets, including full
// and overflowing ones, under several idle and stall mixes.
// ----------------------------------------------------------------------------
module render_batch_order_sorter_tb;

	localparam int IW          = rbos_pkg::BATCH_INDEX_BITS;
	localparam int MAXR        = rbos_pkg::MAX_RECORDS;
	localparam int QUIET_LIMIT = 20000;   // cycles with no item moving on either side
	localparam int HOLD_CYCLES = 400;     // long receiver hold-off
	localparam int ITEM_GOAL   = 370;     // directed plus random items, in all

	// one record as the predictor keeps it
	typedef struct {
		bit                 hud;
		bit                 flood;
		bit                 flat;
		bit                 translucent;
		logic signed [31:0] depth;
		logic [IW-1:0]      idx;
	} batch_rec_t;

	// one result item
	typedef struct packed {
		logic [IW-1:0] idx;
		logic          lst;
		logic          none;
		logic          ovf;
	} draw_res_t;

	// ------------------------------------------------------------------------
	// Scoreboard: keeps its own copy of the open set and the list of
	// draw-order items still to come.
	// ------------------------------------------------------------------------
	class draw_order_board;
		batch_rec_t held[$];
		bit         dropped;
		draw_res_t  draw_list[$];
		int         errors;

		function new();
			dropped = 0;
			errors  = 0;
		endfunction

		// draw group: hud last, otherwise flood, flat, translucent bits
		function int group_rank(batch_rec_t r);
			if (r.hud)
				return 8;
			return (r.flood ? 4 : 0) + (r.flat ? 2 : 0) + (r.translucent ? 1 : 0);
		endfunction

		// a must be drawn strictly ahead of b
		function bit drawn_first(batch_rec_t a, batch_rec_t b);
			int ga;
			int gb;
			ga = group_rank(a);
			gb = group_rank(b);
			if (ga != gb)
				return ga < gb;
			if (!a.hud && a.translucent)
				return a.depth > b.depth;
			return 0;
		endfunction

		function void note_input(bit inc, batch_rec_t r, bit lst);
			batch_rec_t order[$];
			batch_rec_t cur;
			draw_res_t  res;
			bit         special;
			int         j;
			if (inc) begin
				if (held.size() < MAXR)
					held.insert(held.size(), r);
				else
					dropped = 1;
			end
			if (!lst)
				return;
			if (held.size() == 0) begin
				res.idx  = '0;
				res.lst  = 1'b1;
				res.none = 1'b1;
				res.ovf  = dropped;
				draw_list.insert(draw_list.size(), res);
			end else begin
				order   = held;
				special = 0;
				foreach (held[k])
					if (held[k].hud || held[k].flood || held[k].translucent)
						special = 1;
				// stable insertion sort, only when some record is special
				if (special) begin
					for (int i = 1; i < order.size(); i++) begin
						cur = order[i];
						j   = i;
						while (j > 0 && drawn_first(cur, order[j-1])) begin
							order[j] = order[j-1];
							j--;
						end
						order[j] = cur;
					end
				end
				foreach (order[k]) begin
					res.idx  = order[k].idx;
					res.lst  = (k == order.size() - 1);
					res.none = 1'b0;
					res.ovf  = dropped;
					draw_list.insert(draw_list.size(), res);
				end
			end
			held.delete();
			dropped = 0;
		endfunction

		function void check_result(draw_res_t got);
			draw_res_t want;
			if (draw_list.size() == 0) begin
				$display("%0t: unexpected result idx=%0d last=%0b none=%0b ovf=%0b",
					$time, got.idx, got.lst, got.none, got.ovf);
				errors++;
				return;
			end
			want = draw_list.pop_front();
			if (want !== got) begin
				$display("%0t: mismatch expected idx=%0d last=%0b none=%0b ovf=%0b",
					$time, want.idx, want.lst, want.none, want.ovf);
				$display("%0t:          actual   idx=%0d last=%0b none=%0b ovf=%0b",
					$time, got.idx, got.lst, got.none, got.ovf);
				errors++;
			end
		endfunction

		function int outstanding();
			return draw_list.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT signals; the inputs are known from time zero
	// ------------------------------------------------------------------------
	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic              included    = 1'b0;
	logic              hud         = 1'b0;
	logic              flood       = 1'b0;
	logic              flat        = 1'b0;
	logic              translucent = 1'b0;
	logic signed [31:0] sort_depth = '0;
	logic [IW-1:0]     batch_index = '0;
	logic              last        = 1'b0;
	logic              res_valid;
	logic              res_stall   = 1'b0;
	logic [IW-1:0]     batch_index_res;
	logic              last_res;
	logic              none_included;
	logic              overflow;

	draw_order_board sb = new();

	int idle_pct   = 0;   // sender: chance of an idle cycle before each item
	int stall_pct  = 0;   // receiver: chance of stalling in a cycle
	int hold_asks  = 0;   // bumped by the sender to ask for a long hold-off
	int items_sent = 0;

	render_batch_order_sorter uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.included       (included),
		.hud            (hud),
		.flood          (flood),
		.flat           (flat),
		.translucent    (translucent),
		.sort_depth     (sort_depth),
		.batch_index    (batch_index),
		.last           (last),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.batch_index_res(batch_index_res),
		.last_res       (last_res),
		.none_included  (none_included),
		.overflow       (overflow)
	);

	// 4 ns clock
	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Sender: offer one record and wait for it to be taken. Idle cycles are
	// drawn before the item, so gaps land anywhere in a set. in_valid stays
	// high on return; the caller lowers it if nothing follows at once.
	// ------------------------------------------------------------------------
	task automatic send_rec(input bit inc, input bit h, input bit fl, input bit ft,
			input bit tr, input logic [31:0] dep, input logic [IW-1:0] ix, input bit lst);
		batch_rec_t r;
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		included    <= inc;
		hud         <= h;
		flood       <= fl;
		flat        <= ft;
		translucent <= tr;
		sort_depth  <= dep;
		batch_index <= ix;
		last        <= lst;
		do @(posedge clk); while (in_stall !== 1'b0);
		r.hud         = h;
		r.flood       = fl;
		r.flat        = ft;
		r.translucent = tr;
		r.depth       = dep;
		r.idx         = ix;
		sb.note_input(inc, r, lst);
		items_sent++;
	endtask

	// depths: mostly full range, some from a small pool so ties happen
	function automatic logic [31:0] pick_depth();
		if ($urandom_range(0, 99) < 30) begin
			case ($urandom_range(0, 4))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'hFFFF_FFFF;
				3: return 32'h0000_0000;
				default: return 32'h0001_0000;
			endcase
		end
		return $urandom;
	endfunction

	// one random set of n items; plain keeps every record non-special
	task automatic send_random_set(input int n, input bit plain, input int inc_pct);
		bit inc;
		bit h;
		bit fl;
		bit tr;
		for (int k = 0; k < n; k++) begin
			inc = ($urandom_range(0, 99) < inc_pct);
			h   = !plain && ($urandom_range(0, 99) < 20);
			fl  = !plain && ($urandom_range(0, 99) < 25);
			tr  = !plain && ($urandom_range(0, 99) < 40);
			send_rec(inc, h, fl, 1'($urandom_range(0, 1)), tr, pick_depth(),
				IW'($urandom_range(0, (1 << IW) - 1)), k == n - 1);
		end
	endtask

	// ------------------------------------------------------------------------
	// Receiver: checks every taken result, stalls at random, and honors
	// the long hold-off asked by the sender.
	// ------------------------------------------------------------------------
	initial begin
		int        hold_left;
		int        hold_seen;
		draw_res_t got;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0) begin
				got.idx  = batch_index_res;
				got.lst  = last_res;
				got.none = none_included;
				got.ovf  = overflow;
				sb.check_result(got);
			end
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: ends the run if nothing moves for too long
	// ------------------------------------------------------------------------
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
					(res_valid === 1'b1 && res_stall === 1'b0))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		int set_no;
		int kind;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed sets ---
		// nothing included: single none_included item
		send_rec(0, 1, 1, 1, 1, 32'h7FFF_FFFF, '1, 1);
		// lone record with top index and top depth
		send_rec(1, 0, 0, 0, 0, 32'h7FFF_FFFF, '1, 1);
		// plain flats and walls, one left out: arrival order even though flats
		// would otherwise follow walls
		send_rec(1, 0, 0, 1, 0, 32'h0000_0005, 16'd10, 0);
		send_rec(0, 1, 0, 0, 1, 32'h0000_0001, 16'd11, 0);
		send_rec(1, 0, 0, 0, 0, 32'h8000_0000, 16'd0, 1);
		// every group, extreme depths, equal depths, hud with translucent,
		// closed by a record that is not included
		send_rec(1, 1, 0, 0, 1, 32'h0000_0001, 16'd100, 0);   // hud, keeps arrival
		send_rec(1, 0, 0, 0, 1, 32'h8000_0000, 16'd101, 0);   // nearest translucent wall
		send_rec(1, 0, 1, 1, 1, 32'h1234_0000, 16'd102, 0);   // flood flat translucent
		send_rec(1, 0, 0, 0, 1, 32'h7FFF_FFFF, 16'd103, 0);   // farthest translucent wall
		send_rec(1, 0, 0, 1, 0, 32'h0000_0000, 16'd104, 0);   // opaque flat
		send_rec(1, 1, 1, 1, 0, 32'hFFFF_0000, 16'd105, 0);   // hud
		send_rec(1, 0, 0, 0, 1, 32'h0001_0000, 16'd106, 0);   // tie pair, first
		send_rec(1, 0, 1, 0, 0, 32'h0000_0000, 16'd107, 0);   // flood wall opaque
		send_rec(1, 0, 0, 0, 1, 32'h0001_0000, 16'd108, 0);   // tie pair, second
		send_rec(1, 0, 0, 0, 0, 32'hFFFF_FFFF, 16'hFFFF, 0);  // opaque wall
		send_rec(1, 0, 1, 0, 1, 32'hFFFF_FFFF, 16'd110, 0);   // flood wall translucent
		send_rec(1, 0, 0, 1, 1, 32'hC000_0000, 16'd111, 0);   // translucent flat
		send_rec(1, 0, 1, 1, 0, 32'h4000_0000, 16'd112, 0);   // flood flat opaque
		send_rec(1, 1, 0, 1, 1, 32'h7FFF_FFFF, 16'd113, 0);   // hud, depth ignored
		send_rec(0, 0, 0, 0, 1, 32'h0000_0000, 16'd114, 1);   // closes, not stored
		// hud only, last included
		send_rec(1, 1, 0, 0, 0, 32'h0000_0010, 16'd200, 0);
		send_rec(1, 1, 0, 0, 0, 32'h0000_0020, 16'd201, 1);

		// --- random sets ---
		set_no = 0;
		while (items_sent < ITEM_GOAL) begin
			// rotate through the idle and stall mixes every few sets
			case ((set_no / 3) % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 70; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 70; end
				default: begin idle_pct = 28; stall_pct = 28; end
			endcase

			if (set_no == 2)
				send_random_set(67, 0, 100);        // overflows, special records
			else if (set_no == 9)
				send_random_set(MAXR, 1, 100);      // exactly full, arrival order
			else if (set_no == 16)
				send_random_set(70, 0, 97);         // overflows or just fills
			else begin
				kind = $urandom_range(0, 99);
				if (kind < 7)
					send_random_set($urandom_range(1, 3), 0, 0);       // empty set
				else if (kind < 30)
					send_random_set($urandom_range(1, 8), 1, 85);      // plain set
				else if (kind < 90)
					send_random_set($urandom_range(1, 8), 0, 85);
				else
					send_random_set($urandom_range(9, 20), 0, 90);
			end

			// long receiver hold-off while the next set keeps being offered
			if (set_no == 6)
				hold_asks++;
			// sender pause until the set has drained completely
			if (set_no == 12) begin
				in_valid <= 1'b0;
				while (sb.outstanding() != 0) @(posedge clk);
			end
			set_no++;
		end
		in_valid <= 1'b0;

		// drain, then a margin for anything stray
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (150) @(posedge clk);

		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+hdl
hdl/rbos_pkg.sv
hdl/render_batch_order_sorter.sv
verif/render_batch_order_sorter_tb.sv
